### rtl/idwt53_pkg.sv
`timescale 1ns / 1ps
// Package for the reversible 5/3 inverse lifting block.
// Holds the default sample width, the result buffer sizing and the guard bits; no dependencies.
package idwt53_pkg;

   // default width of coefficients and samples
   localparam int SAMPLE_BITS_DEFAULT = 24;

   // most samples that one request can release (line end)
   localparam int MAX_RESULTS = 3;

   // result buffer depth, power of two, at least MAX_RESULTS + 3 for full rate
   localparam int OUT_FIFO_DEPTH = 8;

   // guard bits on top of the sample width for the lifting sums
   localparam int GUARD_BITS = 3;

endpackage

### rtl/idwt53_req_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the 5/3 inverse lifting block.
// Depends on idwt53_pkg for the default sample width.
interface idwt53_req_if #(
   parameter int SAMPLE_BITS = idwt53_pkg::SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] coefficient;
   logic                          line_end;

   modport source (output valid, output coefficient, output line_end, input ready);
   modport sink   (input valid, input coefficient, input line_end, output ready);
endinterface

interface idwt53_rsp_if #(
   parameter int SAMPLE_BITS = idwt53_pkg::SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          sample_last;

   modport source (output valid, output sample, output sample_last, input ready);
   modport sink   (input valid, input sample, input sample_last, output ready);
endinterface

### rtl/inverse_dwt_53_lifting.sv
`timescale 1ns / 1ps
// Reversible 5/3 inverse lifting over one line of interleaved coefficients.
// Depends on idwt53_pkg and the channel interfaces in idwt53_req_if.sv.
//
//   channel   direction  payload                              handshake
//   req_ch    in         coefficient[SB], line_end            valid / ready
//   rsp_ch    out        sample[SB], sample_last              valid / ready
//   csr_*     in         csr_wr_data (start_odd)              csr_wr_en, no wait
//
// One request per cycle is taken while the buffer has room. The lifting adds
// for a request are combinational, from the coefficient window and the even-sample
// hold into an 8-entry result buffer, which hands out one sample per cycle while
// rsp_ch.ready is high. Samples trail their coefficients by two requests; a line
// end releases up to three at once. Requests are taken while at most five results
// are buffered, so a stall on the response side stops requests only beyond five.
// Reset (synchronous) empties the buffer and clears the line state and start_odd.
module inverse_dwt_53_lifting #(
   parameter int SAMPLE_BITS = idwt53_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   idwt53_req_if.sink   req_ch,
   idwt53_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   localparam int IW     = SAMPLE_BITS + idwt53_pkg::GUARD_BITS;
   localparam int DEPTH  = idwt53_pkg::OUT_FIFO_DEPTH;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ENT_W  = SAMPLE_BITS + 1;
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - idwt53_pkg::MAX_RESULTS);
   localparam logic signed [IW-1:0] ROUND_TWO = IW'(2);

   // saturate a wide intermediate to the sample range
   function automatic logic [SAMPLE_BITS-1:0] saturate(input logic signed [IW-1:0] x);
      logic fits;
      fits = (&x[IW-1:SAMPLE_BITS-1]) || ~(|x[IW-1:SAMPLE_BITS-1]);
      if (fits) begin
         return x[SAMPLE_BITS-1:0];
      end else if (x[IW-1]) begin
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   // configuration and line state
   logic                 start_odd_ff;
   logic [1:0]           pos_ff, pos_in;
   logic                 parity_ff, parity_in;
   logic signed [IW-1:0] win1_ff, win2_ff;
   logic signed [IW-1:0] hold0_ff, hold1_ff;
   logic signed [IW-1:0] hold0_in, hold1_in;

   // result buffer
   logic [ENT_W-1:0]     buf_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic                 req_fire, rsp_fire, last, push_even, one_sample, has_mid;
   logic [1:0]           push_n;
   logic                 p;
   logic [1:0]           k;
   logic signed [IW-1:0] v, w0, w1, w2, left_hp, even_new;
   logic signed [IW-1:0] xl_mid, x_mid, xk, xl_end, end_a, end_b;
   logic [ENT_W-1:0]     ent0, ent1, ent2, mid_ent, end_a_ent, end_b_ent;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (cnt_ff <= ROOM_LIMIT);
   assign rsp_ch.valid = (cnt_ff != '0);
   assign rsp_ch.sample      = buf_ff[rd_ptr_ff][SAMPLE_BITS-1:0];
   assign rsp_ch.sample_last = buf_ff[rd_ptr_ff][SAMPLE_BITS];

   // lifting for the request at the port
   always_comb begin
      last = req_ch.line_end;
      k    = pos_ff;
      p    = (pos_ff == 2'd0) ? start_odd_ff : parity_ff;
      v    = IW'(req_ch.coefficient);
      w0   = win1_ff;
      w1   = win2_ff;
      w2   = v;

      one_sample = last && (k == 2'd0);

      // previous coefficient was lowpass: rebuild it now its right neighbour is here
      push_even = (k != 2'd0) && p;
      left_hp   = (k >= 2'd2) ? w0 : w2;
      even_new  = w1 - ((left_hp + w2 + ROUND_TWO) >>> 2);
      hold0_in  = push_even ? hold1_ff : hold0_ff;
      hold1_in  = push_even ? even_new : hold1_ff;

      // sample two places back
      xl_mid = (k == 2'd3) ? hold0_in : hold1_in;
      x_mid  = p ? (w0 + ((xl_mid + hold1_in) >>> 1)) : hold1_in;

      // the two closing samples of a line
      xk     = w2 - (((w1 <<< 1) + ROUND_TWO) >>> 2);
      xl_end = (k >= 2'd2) ? hold1_in : xk;
      if (p) begin
         end_a = hold1_in;
         end_b = w2 + hold1_in;
      end else begin
         end_a = w1 + ((xl_end + xk) >>> 1);
         end_b = xk;
      end

      has_mid   = (k >= 2'd2);
      mid_ent   = {1'b0, saturate(x_mid)};
      end_a_ent = {1'b0, saturate(end_a)};
      end_b_ent = {1'b1, saturate(end_b)};

      // pack results in line order
      if (one_sample) begin
         ent0   = {1'b1, saturate(p ? (v >>> 1) : v)};
         ent1   = end_b_ent;
         ent2   = end_b_ent;
         push_n = 2'd1;
      end else if (has_mid) begin
         ent0   = mid_ent;
         ent1   = end_a_ent;
         ent2   = end_b_ent;
         push_n = last ? 2'd3 : 2'd1;
      end else begin
         ent0   = end_a_ent;
         ent1   = end_b_ent;
         ent2   = end_b_ent;
         push_n = last ? 2'd2 : 2'd0;
      end

      pos_in    = last ? 2'd0 : ((k == 2'd3) ? 2'd3 : k + 2'd1);
      parity_in = last ? p : ~p;
   end

   // buffer occupancy after this cycle's pushes and pop
   always_comb begin
      cnt_in = cnt_ff;
      if (req_fire) begin
         cnt_in = cnt_in + CNT_W'(push_n);
      end
      if (rsp_fire) begin
         cnt_in = cnt_in - CNT_W'(1);
      end
   end

   // hold line state, advance window and buffer pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_odd_ff <= 1'b0;
         pos_ff       <= 2'd0;
         parity_ff    <= 1'b0;
         win1_ff      <= '0;
         win2_ff      <= '0;
         hold0_ff     <= '0;
         hold1_ff     <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            start_odd_ff <= csr_wr_data;
         end
         if (req_fire) begin
            pos_ff    <= pos_in;
            parity_ff <= parity_in;
            win1_ff   <= win2_ff;
            win2_ff   <= v;
            hold0_ff  <= hold0_in;
            hold1_ff  <= hold1_in;
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_n);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

   // write results into the buffer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (push_n != 2'd0) begin
            buf_ff[wr_ptr_ff] <= ent0;
         end
         if (push_n >= 2'd2) begin
            buf_ff[wr_ptr_ff + PTR_W'(1)] <= ent1;
         end
         if (push_n == 2'd3) begin
            buf_ff[wr_ptr_ff + PTR_W'(2)] <= ent2;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("result buffer overfilled");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      PTR_W'(wr_ptr_ff - rd_ptr_ff) == cnt_ff[PTR_W-1:0])
      else $error("buffer pointers disagree with count");

   a_line_start_quiet: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_ch.line_end && (pos_ff != 2'd2) && (pos_ff != 2'd3)
      |-> push_n == 2'd0)
      else $error("result released during line start");

   a_line_end_resets: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.line_end |=> pos_ff == 2'd0)
      else $error("line position not cleared at line end");

   a_one_sample: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.line_end && (pos_ff == 2'd0) |-> push_n == 2'd1)
      else $error("one-sample line must release exactly one sample");
`endif

endmodule
